[hdl/msort_pkg.sv]
// ----------------------------------------------------------------------------
// msort_pkg
// Shared types and constants for the merge sort engine: data width, the
// controller-to-datapath command set and the datapath status bundle.
// ----------------------------------------------------------------------------
package msort_pkg;

  localparam int DATA_W = 32;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_RUN_INIT,
    OP_PRIME,
    OP_STEP,
    OP_ADVANCE,
    OP_EMIT_RD,
    OP_EMIT_LOAD,
    OP_EMIT_NEXT
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic single;       // fewer than two elements held
    logic run_end;      // current merge step writes the last slot of the run
    logic more_runs;    // another run follows in this pass
    logic more_passes;  // another pass follows this one
    logic emit_last;    // element being emitted is the final one
  } status_t;

endpackage

[hdl/merge_sort_engine_unit.sv]
// ----------------------------------------------------------------------------
// merge_sort_engine_unit
// Collects a set of signed 32-bit values, sorts it with a stable bottom-up
// merge sort and streams the sorted set back out.
// ----------------------------------------------------------------------------
// Usage: stream values in on the slave side, one per cycle while s_tready is
// high, and mark the final value of the set with s_tlast. Up to MAX_COUNT
// values are kept; later ones are discarded and m_tuser (dropped) goes high on
// the final sorted result. After the set closes the input is held off while
// the block sorts: with n values held the sort takes ceil(log2 n) passes, each
// pass making one merge step per element through the ping-pong memories,
// with setup, priming and advance states around each run. Sorted values then
// leave in ascending order, each registered before it is presented, the final
// one with m_tlast; the next set is accepted right after that request is
// taken. Equal values keep their arrival order. The merge rate is set by the
// single read port of each element memory: one head is refilled per cycle.
// ----------------------------------------------------------------------------
module merge_sort_engine_unit #(
  parameter int MAX_COUNT = 64
) (
  input  logic        clk,
  input  logic        rst,
  // Slave side
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] value
  input  logic        s_tlast,   // last_in
  // Master side
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] sorted_value
  output logic        m_tlast,   // last_out
  output logic        m_tuser    // [0] dropped
);

  msort_pkg::cmd_t    cmd;
  msort_pkg::status_t status;

  // Sequencer: owns both handshakes
  msort_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tlast  (s_tlast),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // Memories, counters, merge compare and the output register
  msort_dp #(.MAX_COUNT(MAX_COUNT)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .in_value    (s_tdata),
    .in_last     (s_tlast),
    .out_value   (m_tdata),
    .out_last    (m_tlast),
    .out_dropped (m_tuser)
  );

  // Loading and emitting never overlap
  assert property (@(posedge clk) disable iff (rst) !(s_tready && m_tvalid))
    else $error("input open while a result is presented");

  // Closing a set stops the input until its results are out
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tlast) |=> !s_tready)
    else $error("input still open after end of set");

  // Delivering the final result reopens the input
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> (s_tready && !m_tvalid))
    else $error("input not reopened after final result");

  // The dropped flag only rides on the final result
  assert property (@(posedge clk) disable iff (rst) (m_tvalid && m_tuser) |-> m_tlast)
    else $error("dropped flag on a non-final result");

endmodule

[hdl/msort_ram.sv]
// ----------------------------------------------------------------------------
// msort_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module msort_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/msort_ctrl.sv]
// ----------------------------------------------------------------------------
// msort_ctrl
// Sequencer for the merge sort engine: load, bottom-up merge passes and
// emission, issuing one command per cycle to the datapath.
// ----------------------------------------------------------------------------
module msort_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  input  logic                s_tlast,
  output logic                s_tready,
  output logic                m_tvalid,
  input  logic                m_tready,
  input  msort_pkg::status_t  status,
  output msort_pkg::cmd_t     cmd
);

  typedef enum logic [3:0] {
    S_LOAD,
    S_START,
    S_RUN_INIT,
    S_PRIME,
    S_STEP,
    S_ADV,
    S_EMIT_RD,
    S_EMIT_LOAD,
    S_EMIT_WAIT
  } state_t;

  state_t state;

  assign s_tready = (state == S_LOAD);

  always_comb begin
    cmd.op = msort_pkg::OP_NONE;
    case (state)
      S_LOAD:      cmd.op = s_tvalid ? msort_pkg::OP_LOAD : msort_pkg::OP_NONE;
      S_START:     cmd.op = msort_pkg::OP_NONE;
      S_RUN_INIT:  cmd.op = msort_pkg::OP_RUN_INIT;
      S_PRIME:     cmd.op = msort_pkg::OP_PRIME;
      S_STEP:      cmd.op = msort_pkg::OP_STEP;
      S_ADV:       cmd.op = msort_pkg::OP_ADVANCE;
      S_EMIT_RD:   cmd.op = msort_pkg::OP_EMIT_RD;
      S_EMIT_LOAD: cmd.op = msort_pkg::OP_EMIT_LOAD;
      S_EMIT_WAIT: cmd.op = m_tready ? msort_pkg::OP_EMIT_NEXT : msort_pkg::OP_NONE;
      default:     cmd.op = msort_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_LOAD;
      m_tvalid <= 1'b0;
    end else begin
      case (state)
        S_LOAD: begin
          if (s_tvalid && s_tlast) begin
            state <= S_START;
          end
        end
        S_START: begin
          state <= status.single ? S_EMIT_RD : S_RUN_INIT;
        end
        S_RUN_INIT: state <= S_PRIME;
        S_PRIME:    state <= S_STEP;
        S_STEP: begin
          if (status.run_end) begin
            state <= S_ADV;
          end
        end
        S_ADV: begin
          state <= (status.more_runs || status.more_passes) ? S_RUN_INIT : S_EMIT_RD;
        end
        S_EMIT_RD: state <= S_EMIT_LOAD;
        S_EMIT_LOAD: begin
          state    <= S_EMIT_WAIT;
          m_tvalid <= 1'b1;
        end
        S_EMIT_WAIT: begin
          if (m_tready) begin
            m_tvalid <= 1'b0;
            state    <= status.emit_last ? S_LOAD : S_EMIT_LOAD;
          end
        end
        default: begin
          state    <= S_LOAD;
          m_tvalid <= 1'b0;
        end
      endcase
    end
  end

endmodule

[hdl/msort_dp.sv]
// ----------------------------------------------------------------------------
// msort_dp
// Datapath: two ping-pong element memories, run and pass counters, the
// merge compare and the output register.
// ----------------------------------------------------------------------------
module msort_dp #(
  parameter int MAX_COUNT = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  msort_pkg::cmd_t               cmd,
  output msort_pkg::status_t            status,
  input  logic [msort_pkg::DATA_W-1:0]  in_value,
  input  logic                          in_last,
  output logic [msort_pkg::DATA_W-1:0]  out_value,
  output logic                          out_last,
  output logic                          out_dropped
);

  localparam int AW = (MAX_COUNT > 1) ? $clog2(MAX_COUNT) : 1;
  localparam int CW = $clog2(MAX_COUNT + 1);
  localparam int SW = CW + 2;

  typedef logic [msort_pkg::DATA_W-1:0] word_t;

  // Load and emit bookkeeping
  logic [CW-1:0] count;
  logic [CW-1:0] n;
  logic [CW-1:0] k;
  logic          overflow;
  logic          src_sel;

  // Merge bookkeeping
  logic [SW-1:0] lo, w, mid, hi, ia, ib, o;
  word_t         head_a, head_b;
  logic          pend_b;

  // Memories
  logic          we0, we1;
  logic [AW-1:0] waddr0, raddr;
  word_t         wdata0, rd0, rd1, rdata;

  logic          full;
  logic [SW-1:0] n_w, lo_w, lo_2w, mid_c, hi_c, ia_inc, ib_inc;
  logic [CW-1:0] k_inc;
  word_t         ha, hb, win;
  logic          a_ok, b_ok, take_a;

  assign full   = (count == CW'(MAX_COUNT));
  assign n_w    = SW'(n);
  assign lo_w   = lo + w;
  assign lo_2w  = lo + (w << 1);
  assign mid_c  = (lo_w > n_w) ? n_w : lo_w;
  assign hi_c   = (lo_2w > n_w) ? n_w : lo_2w;
  assign ia_inc = ia + SW'(1);
  assign ib_inc = ib + SW'(1);
  assign k_inc  = k + CW'(1);

  assign rdata  = src_sel ? rd1 : rd0;
  // The read data holds whichever head was refilled last cycle
  assign ha     = pend_b ? head_a : rdata;
  assign hb     = pend_b ? rdata : head_b;
  assign a_ok   = (ia < mid);
  assign b_ok   = (ib < hi);
  assign take_a = a_ok && (!b_ok || ($signed(ha) <= $signed(hb)));
  assign win    = take_a ? ha : hb;

  always_comb begin
    case (cmd.op)
      msort_pkg::OP_RUN_INIT:  raddr = lo[AW-1:0];
      msort_pkg::OP_PRIME:     raddr = ib[AW-1:0];
      msort_pkg::OP_STEP:      raddr = take_a ? ia_inc[AW-1:0] : ib_inc[AW-1:0];
      msort_pkg::OP_EMIT_NEXT: raddr = k_inc[AW-1:0];
      default:                 raddr = k[AW-1:0];
    endcase
  end

  assign we0    = ((cmd.op == msort_pkg::OP_LOAD) && !full) ||
                  ((cmd.op == msort_pkg::OP_STEP) && src_sel);
  assign we1    = (cmd.op == msort_pkg::OP_STEP) && !src_sel;
  assign waddr0 = (cmd.op == msort_pkg::OP_LOAD) ? count[AW-1:0] : o[AW-1:0];
  assign wdata0 = (cmd.op == msort_pkg::OP_LOAD) ? in_value : win;

  msort_ram #(.WIDTH(msort_pkg::DATA_W), .DEPTH(MAX_COUNT)) u_mem0 (
    .clk   (clk),
    .we    (we0),
    .waddr (waddr0),
    .wdata (wdata0),
    .raddr (raddr),
    .rdata (rd0)
  );

  msort_ram #(.WIDTH(msort_pkg::DATA_W), .DEPTH(MAX_COUNT)) u_mem1 (
    .clk   (clk),
    .we    (we1),
    .waddr (o[AW-1:0]),
    .wdata (win),
    .raddr (raddr),
    .rdata (rd1)
  );

  assign status.single      = (n < CW'(2));
  assign status.run_end     = ((o + SW'(1)) == hi);
  assign status.more_runs   = (lo_2w < n_w);
  assign status.more_passes = ((w << 1) < n_w);
  assign status.emit_last   = (k_inc == n);

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      overflow <= 1'b0;
    end else begin
      case (cmd.op)
        msort_pkg::OP_LOAD: begin
          if (!full) begin
            count <= count + CW'(1);
          end else begin
            overflow <= 1'b1;
          end
        end
        msort_pkg::OP_EMIT_NEXT: begin
          if (k_inc == n) begin
            count    <= '0;
            overflow <= 1'b0;
          end
        end
        default: begin
          count <= count;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      msort_pkg::OP_LOAD: begin
        if (in_last) begin
          n       <= full ? count : count + CW'(1);
          w       <= SW'(1);
          lo      <= '0;
          k       <= '0;
          src_sel <= 1'b0;
        end
      end
      msort_pkg::OP_RUN_INIT: begin
        ia  <= lo;
        ib  <= mid_c;
        mid <= mid_c;
        hi  <= hi_c;
        o   <= lo;
      end
      msort_pkg::OP_PRIME: begin
        head_a <= rdata;
        pend_b <= 1'b1;
      end
      msort_pkg::OP_STEP: begin
        head_a <= ha;
        head_b <= hb;
        pend_b <= !take_a;
        o      <= o + SW'(1);
        if (take_a) begin
          ia <= ia_inc;
        end else begin
          ib <= ib_inc;
        end
      end
      msort_pkg::OP_ADVANCE: begin
        if (lo_2w < n_w) begin
          lo <= lo_2w;
        end else begin
          lo      <= '0;
          w       <= w << 1;
          src_sel <= !src_sel;
        end
      end
      msort_pkg::OP_EMIT_LOAD: begin
        out_value   <= rdata;
        out_last    <= (k_inc == n);
        out_dropped <= (k_inc == n) && overflow;
      end
      msort_pkg::OP_EMIT_NEXT: begin
        k <= k_inc;
      end
      default: begin
        k <= k;
      end
    endcase
  end

endmodule

[bench/merge_sort_engine_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// merge_sort_engine_unit_tb
// Streams sets of signed values into the sort engine and checks every sorted
// result against an in-bench predictor. The run starts with a short table of
// hand-picked sets: single elements at the extremes, duplicates and
// presorted runs. A set one past capacity follows, then random sets.
// Both stream sides stall at random, except during the capacity set.
// ----------------------------------------------------------------------------
module merge_sort_engine_unit_tb;

  localparam int MAX_COUNT    = 64;
  localparam int RANDOM_ITEMS = 24;
  // Longest quiet stretch of a correct run is one full-capacity sort;
  // allow several times that.
  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 64;

  typedef logic signed [msort_pkg::DATA_W-1:0] elem_t;

  typedef struct packed {
    elem_t value;
    logic  last;
    logic  dropped;
  } sorted_item_t;

  // One row of the opening table. When typed is set, the row closes a
  // one-element set and exp_value is the single result it must produce.
  typedef struct packed {
    elem_t value;
    logic  last;
    logic  typed;
    elem_t exp_value;
  } stim_row_t;

  localparam int DIRECTED_ROWS = 21;
  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    // one-element sets: first request after reset, then the extremes
    '{32'h8000_0000, 1'b1, 1'b1, 32'h8000_0000},
    '{32'h7FFF_FFFF, 1'b1, 1'b1, 32'h7FFF_FFFF},
    '{32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000},
    '{32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF},
    // mixed set with a duplicate and both extremes
    '{32'h0000_0005, 1'b0, 1'b0, 32'h0},
    '{32'hFFFF_FFFD, 1'b0, 1'b0, 32'h0},
    '{32'h0000_0005, 1'b0, 1'b0, 32'h0},
    '{32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0},
    '{32'h8000_0000, 1'b0, 1'b0, 32'h0},
    '{32'h0000_0000, 1'b1, 1'b0, 32'h0},
    // equal pair
    '{32'h0000_0007, 1'b0, 1'b0, 32'h0},
    '{32'h0000_0007, 1'b1, 1'b0, 32'h0},
    // descending run
    '{32'h0000_0003, 1'b0, 1'b0, 32'h0},
    '{32'h0000_0002, 1'b0, 1'b0, 32'h0},
    '{32'h0000_0001, 1'b1, 1'b0, 32'h0},
    // ascending run
    '{32'h0000_0001, 1'b0, 1'b0, 32'h0},
    '{32'h0000_0002, 1'b0, 1'b0, 32'h0},
    '{32'h0000_0003, 1'b1, 1'b0, 32'h0},
    // alternating bit patterns, the second one negative
    '{32'h5555_5555, 1'b0, 1'b0, 32'h0},
    '{32'hAAAA_AAAA, 1'b1, 1'b0, 32'h0},
    // one-element set after the multi-element ones
    '{32'h0000_002A, 1'b1, 1'b1, 32'h0000_002A}
  };

  logic                        clk;
  logic                        rst;
  logic                        s_tvalid;
  logic                        s_tready;
  logic [msort_pkg::DATA_W-1:0] s_tdata;
  logic                        s_tlast;
  logic                        m_tvalid;
  logic                        m_tready = 1'b0;
  logic [msort_pkg::DATA_W-1:0] m_tdata;
  logic                        m_tlast;
  logic                        m_tuser;

  // Predictor state: the open set and whether it lost an element.
  elem_t        held_set [$];
  logic         overflow_hit = 1'b0;
  // Sorted results still owed by the block, oldest first.
  sorted_item_t sorted_q [$];

  int mismatches  = 0;
  int idle_cycles = 0;
  // No random stalls on either side while set.
  bit calm        = 1'b0;

  merge_sort_engine_unit #(
    .MAX_COUNT(MAX_COUNT)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Add one accepted request to the open set. On last, sort the set stably
  // and queue its results (unless the row supplied its own), then close it.
  task automatic absorb_request(input elem_t v, input logic l, input logic record);
    elem_t        ordered [$];
    elem_t        key;
    int           j;
    sorted_item_t item;
    if (held_set.size() < MAX_COUNT) begin
      held_set.push_back(v);
    end else begin
      overflow_hit = 1'b1;
    end
    if (l) begin
      ordered = held_set;
      // Insertion sort: shift only strictly greater keys, so ties keep order.
      for (int i = 1; i < ordered.size(); i++) begin
        key = ordered[i];
        j   = i - 1;
        while (j >= 0 && ordered[j] > key) begin
          ordered[j + 1] = ordered[j];
          j--;
        end
        ordered[j + 1] = key;
      end
      if (record) begin
        foreach (ordered[k]) begin
          item.value   = ordered[k];
          item.last    = (k == ordered.size() - 1);
          item.dropped = item.last & overflow_hit;
          sorted_q.push_back(item);
        end
      end
      held_set.delete();
      overflow_hit = 1'b0;
    end
  endtask

  // Present one request, with a random gap first unless calm, and hold it until taken.
  // Returns in the time step of the accepting edge.
  task automatic send_request(input elem_t v, input logic l);
    if (!calm) begin
      while ($urandom_range(99) < 31) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    s_tlast  <= l;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Drop valid and hold off until every owed result has come back.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sorted_q.size() != 0) @(posedge clk);
  endtask

  // Mix of extremes, near-zero values (for ties) and full-range noise.
  function automatic elem_t pick_value();
    case ($urandom_range(9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2, 3:    return elem_t'(int'($urandom_range(6)) - 3);
      default: return elem_t'($urandom);
    endcase
  endfunction

  // Receiver: stall at random and check each result taken.
  always @(posedge clk) begin : result_check
    sorted_item_t want;
    m_tready <= calm || ($urandom_range(99) >= 31);
    if (!rst && m_tvalid && m_tready) begin
      if (sorted_q.size() == 0) begin
        $error("unexpected result: sorted_value %0d last_out %0b dropped %0b",
               $signed(m_tdata), m_tlast, m_tuser);
        mismatches++;
      end else begin
        want = sorted_q.pop_front();
        if (m_tdata !== want.value) begin
          $error("sorted_value: expected %0d, got %0d", want.value, $signed(m_tdata));
          mismatches++;
        end
        if (m_tlast !== want.last) begin
          $error("last_out: expected %0b, got %0b", want.last, m_tlast);
          mismatches++;
        end
        if (m_tuser !== want.dropped) begin
          $error("dropped: expected %0b, got %0b", want.dropped, m_tuser);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: end the run if no request moves on either side for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin : stimulus
    sorted_item_t single;
    int           set_size;
    int           sent;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tlast  <= 1'b0;
    rst      <= 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Opening table; typed rows carry their own single expected result.
    foreach (DIRECTED[r]) begin
      send_request(DIRECTED[r].value, DIRECTED[r].last);
      if (DIRECTED[r].typed) begin
        single.value   = DIRECTED[r].exp_value;
        single.last    = 1'b1;
        single.dropped = 1'b0;
        sorted_q.push_back(single);
      end
      absorb_request(DIRECTED[r].value, DIRECTED[r].last, !DIRECTED[r].typed);
    end

    // Hold the sender until the table is fully drained.
    wait_drained();

    // Capacity set: one past full, so the store fills and the closing
    // request itself is discarded while still closing the set. Run it and
    // its results with no stalls on either side.
    calm = 1'b1;
    for (int i = 0; i < MAX_COUNT + 1; i++) begin
      elem_t v;
      v = pick_value();
      send_request(v, i == MAX_COUNT);
      absorb_request(v, i == MAX_COUNT, 1'b1);
    end
    wait_drained();
    calm = 1'b0;

    // Random sets, mostly small.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      set_size = ($urandom_range(7) == 0) ? $urandom_range(20, 9) : $urandom_range(8, 1);
      for (int i = 0; i < set_size; i++) begin
        elem_t v;
        v = pick_value();
        send_request(v, i == set_size - 1);
        absorb_request(v, i == set_size - 1, 1'b1);
        sent++;
      end
      if ($urandom_range(9) == 0) wait_drained();
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
